// ===== sv/ata_taskfile_command_setup_core_assert.svh =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: assertion macros
// Shared forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef ATA_TASKFILE_COMMAND_SETUP_CORE_ASSERT_SVH
`define ATA_TASKFILE_COMMAND_SETUP_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ATCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("atcs: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ATCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("atcs: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define ATCS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("atcs: reset check failed");

`endif

// ===== sv/atcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: package
// Beat types, register offsets, command codes and CHS constants.
// ----------------------------------------------------------------------------
`default_nettype none

package atcs_pkg;

    // Request beat.
    typedef struct packed {
        logic        direction;
        logic [31:0] block_address;
        logic [7:0]  sector_count;
        logic        drive_slave;
        logic        lba_capable;
    } t_req_beat;

    // One command-block register write.
    typedef struct packed {
        logic [2:0] reg_offset;
        logic [7:0] reg_value;
        logic [1:0] address_mode;
        logic       last_write;
    } t_wr_beat;

    // Classified job handed from the front to the back.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] device;
        logic [7:0] high_addr;
        logic [7:0] count;
        logic [7:0] addr0;
        logic [7:0] addr1;
        logic [7:0] addr2;
        logic [7:0] command;
    } t_job;

    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_ADDR0   = 3'd3;
    localparam logic [2:0] REG_ADDR1   = 3'd4;
    localparam logic [2:0] REG_ADDR2   = 3'd5;
    localparam logic [2:0] REG_DEVICE  = 3'd6;
    localparam logic [2:0] REG_COMMAND = 3'd7;

    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    localparam logic [7:0] DEV_BASE_CHS = 8'hA0;
    localparam logic [7:0] DEV_BASE_LBA = 8'hE0;

    // Exact division of a 28-bit value by 63: q = (x * RECIP_63) >> RECIP_SHIFT.
    localparam int         LBA28_W     = 28;
    localparam int         RECIP_W     = 29;
    localparam int         PROD_W      = LBA28_W + RECIP_W;
    localparam int         RECIP_SHIFT = 34;
    localparam int         QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_63 = 29'd272696337;

endpackage

`default_nettype wire

// ===== sv/atcs_front.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: front end
// Accepts requests, picks the address mode and works out the job's register bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module atcs_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_stall,
    input  wire atcs_pkg::t_req_beat i_req,
    output logic                   o_push,
    output atcs_pkg::t_job         o_job,
    input  wire logic              i_full
);

    logic                             r_vld;
    atcs_pkg::t_req_beat              r_req;
    logic [atcs_pkg::PROD_W-1:0]      r_prod;
    logic                             load;

    logic [atcs_pkg::QUOT_W-1:0]      quot;
    logic [atcs_pkg::LBA28_W-1:0]     rem_full;
    logic [5:0]                       sect;
    logic [1:0]                       mode;

    assign o_req_stall = r_vld && i_full;
    assign load        = i_req_valid && !o_req_stall;
    assign o_push      = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    // The product by the reciprocal of 63 is registered with the request.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req  <= i_req;
            r_prod <= atcs_pkg::PROD_W'(i_req.block_address[atcs_pkg::LBA28_W-1:0])
                      * atcs_pkg::PROD_W'(atcs_pkg::RECIP_63);
        end
    end

    // Quotient by 63 is exact; the remainder is x - 64q + q.
    assign quot     = r_prod[atcs_pkg::PROD_W-1:atcs_pkg::RECIP_SHIFT];
    assign rem_full = r_req.block_address[atcs_pkg::LBA28_W-1:0]
                      - {quot[atcs_pkg::LBA28_W-7:0], 6'b0}
                      + atcs_pkg::LBA28_W'(quot);
    assign sect     = rem_full[5:0] + 6'd1;

    always_comb begin
        if (|r_req.block_address[31:28]) begin
            mode = atcs_pkg::MODE_LBA48;
        end else if (r_req.lba_capable) begin
            mode = atcs_pkg::MODE_LBA28;
        end else begin
            mode = atcs_pkg::MODE_CHS;
        end
    end

    always_comb begin
        o_job.mode      = mode;
        o_job.count     = r_req.sector_count;
        o_job.high_addr = r_req.block_address[31:24];
        case (mode)
            atcs_pkg::MODE_LBA48: begin
                o_job.device  = atcs_pkg::DEV_BASE_LBA | {3'b0, r_req.drive_slave, 4'b0};
                o_job.addr0   = r_req.block_address[7:0];
                o_job.addr1   = r_req.block_address[15:8];
                o_job.addr2   = r_req.block_address[23:16];
                o_job.command = r_req.direction ? atcs_pkg::CMD_WRITE_EXT
                                                : atcs_pkg::CMD_READ_EXT;
            end
            atcs_pkg::MODE_LBA28: begin
                o_job.device  = atcs_pkg::DEV_BASE_LBA
                                | {3'b0, r_req.drive_slave, r_req.block_address[27:24]};
                o_job.addr0   = r_req.block_address[7:0];
                o_job.addr1   = r_req.block_address[15:8];
                o_job.addr2   = r_req.block_address[23:16];
                o_job.command = r_req.direction ? atcs_pkg::CMD_WRITE : atcs_pkg::CMD_READ;
            end
            default: begin
                // CHS: head is the quotient mod 16, cylinder the quotient over 16.
                o_job.device  = atcs_pkg::DEV_BASE_CHS
                                | {3'b0, r_req.drive_slave, quot[3:0]};
                o_job.addr0   = {2'b0, sect};
                o_job.addr1   = quot[11:4];
                o_job.addr2   = quot[19:12];
                o_job.command = r_req.direction ? atcs_pkg::CMD_WRITE : atcs_pkg::CMD_READ;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/atcs_queue.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: job queue
// Small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module atcs_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire atcs_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_not_empty,
    output atcs_pkg::t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    atcs_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/atcs_back.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: back end
// Steps through one job's register writes into a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module atcs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_not_empty,
    input  wire atcs_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_wr_valid,
    input  wire logic           i_wr_stall,
    output atcs_pkg::t_wr_beat  o_wr
);

    localparam logic [3:0] STEP_DEVICE   = 4'd0;
    localparam logic [3:0] STEP_HI_COUNT = 4'd1;
    localparam logic [3:0] STEP_HI_ADDR0 = 4'd2;
    localparam logic [3:0] STEP_HI_ADDR1 = 4'd3;
    localparam logic [3:0] STEP_HI_ADDR2 = 4'd4;
    localparam logic [3:0] STEP_COUNT    = 4'd5;
    localparam logic [3:0] STEP_ADDR0    = 4'd6;
    localparam logic [3:0] STEP_ADDR1    = 4'd7;
    localparam logic [3:0] STEP_ADDR2    = 4'd8;
    localparam logic [3:0] STEP_COMMAND  = 4'd9;

    logic [3:0]          r_step;
    logic [3:0]          n_step;
    logic                r_wr_valid;
    atcs_pkg::t_wr_beat  r_wr;
    atcs_pkg::t_wr_beat  n_wr;
    logic                advance;

    assign advance    = i_not_empty && (!r_wr_valid || !i_wr_stall);
    assign o_pop      = advance && (r_step == STEP_COMMAND);
    assign o_wr_valid = r_wr_valid;
    assign o_wr       = r_wr;

    always_comb begin
        n_wr.address_mode = i_job.mode;
        n_wr.last_write   = 1'b0;
        case (r_step)
            STEP_DEVICE: begin
                n_wr.reg_offset = atcs_pkg::REG_DEVICE;
                n_wr.reg_value  = i_job.device;
            end
            STEP_HI_COUNT: begin
                n_wr.reg_offset = atcs_pkg::REG_COUNT;
                n_wr.reg_value  = 8'h00;
            end
            STEP_HI_ADDR0: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR0;
                n_wr.reg_value  = i_job.high_addr;
            end
            STEP_HI_ADDR1: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR1;
                n_wr.reg_value  = 8'h00;
            end
            STEP_HI_ADDR2: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR2;
                n_wr.reg_value  = 8'h00;
            end
            STEP_COUNT: begin
                n_wr.reg_offset = atcs_pkg::REG_COUNT;
                n_wr.reg_value  = i_job.count;
            end
            STEP_ADDR0: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR0;
                n_wr.reg_value  = i_job.addr0;
            end
            STEP_ADDR1: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR1;
                n_wr.reg_value  = i_job.addr1;
            end
            STEP_ADDR2: begin
                n_wr.reg_offset = atcs_pkg::REG_ADDR2;
                n_wr.reg_value  = i_job.addr2;
            end
            default: begin
                n_wr.reg_offset = atcs_pkg::REG_COMMAND;
                n_wr.reg_value  = i_job.command;
                n_wr.last_write = 1'b1;
            end
        endcase
    end

    // Only LBA48 visits the high-order writes.
    always_comb begin
        if (r_step == STEP_DEVICE) begin
            n_step = (i_job.mode == atcs_pkg::MODE_LBA48) ? STEP_HI_COUNT : STEP_COUNT;
        end else if (r_step >= STEP_COMMAND) begin
            n_step = STEP_DEVICE;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_DEVICE;
            r_wr_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step <= n_step;
            end
            if (!r_wr_valid || !i_wr_stall) begin
                r_wr_valid <= i_not_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_wr <= n_wr;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ata_taskfile_command_setup_core.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup core
// Turns a PIO transfer request into its ordered command-block register writes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                  Payload
//   request   in          i_req_valid / o_req_stall  i_req (t_req_beat)
//   write     out         o_wr_valid  / i_wr_stall   o_wr  (t_wr_beat)
//
// An LBA48 request produces ten write beats, CHS and LBA28 requests six, one
// beat per cycle from the back-end step counter when the sink does not stall.
// The front end registers an accepted request together with its reciprocal
// product for the CHS split, forms the job bytes from that register and pushes
// the job into the queue once the queue is not full; the back end then loads
// the first write beat into its output register. A request is stalled only
// while the front stage holds a job that the full queue cannot take.
// Reset is synchronous and active low; it empties the front stage, the queue
// and the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_taskfile_command_setup_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_stall,
    input  wire atcs_pkg::t_req_beat i_req,
    output logic                     o_wr_valid,
    input  wire logic                i_wr_stall,
    output atcs_pkg::t_wr_beat       o_wr
);

    // Jobs travel from the front end to the back end through the queue.
    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;
    atcs_pkg::t_job front_job;
    atcs_pkg::t_job head_job;

    // Front end: accepts a request beat, decides CHS, LBA28 or LBA48 and
    // computes every byte of the job, including the CHS geometry.
    atcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (full)
    );

    // The queue lets a new request be classified while the back end is still
    // emitting the previous sequence or is held by the sink.
    atcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_job       (head_job)
    );

    // Back end: walks the write order of the head job and pops it once the
    // command write has been loaded into the output register.
    atcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_wr_valid  (o_wr_valid),
        .i_wr_stall  (i_wr_stall),
        .o_wr        (o_wr)
    );

endmodule

`default_nettype wire

// ===== sv/atcs_checker.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: port checker
// Checks on the write channel of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ata_taskfile_command_setup_core_assert.svh"

module atcs_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_wr_valid,
    input wire logic               i_wr_stall,
    input wire atcs_pkg::t_wr_beat i_wr
);

    logic wr_held;
    logic last_taken;
    logic is_cmd;
    logic is_dev;

    assign wr_held    = i_wr_valid && i_wr_stall;
    assign last_taken = i_wr_valid && !i_wr_stall && i_wr.last_write;
    assign is_cmd     = (i_wr.reg_offset == atcs_pkg::REG_COMMAND);
    assign is_dev     = (i_wr.reg_offset == atcs_pkg::REG_DEVICE);

    // A stalled write beat is held.
    `ATCS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, wr_held, i_wr_valid && $stable(i_wr))

    // The command register write, and only it, closes a sequence.
    `ATCS_ASSERT_IMP(a_last_is_cmd, i_clk, i_rst_n, i_wr_valid, i_wr.last_write == is_cmd)

    // The next sequence opens with the device register write.
    `ATCS_ASSERT_NXT(a_dev_first, i_clk, i_rst_n, last_taken, !i_wr_valid || is_dev)

    // Reset leaves no write beat behind.
    `ATCS_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !i_wr_valid)

endmodule

bind ata_taskfile_command_setup_core atcs_checker u_atcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_wr_valid (o_wr_valid),
    .i_wr_stall (i_wr_stall),
    .i_wr       (o_wr)
);

`default_nettype wire
